[design/csp_pkg.sv]
// csp_pkg: shared types, constants and basis tables for the cubic spline point evaluator
// no dependencies; imported by every module of the block except the generic ram
package csp_pkg;

	localparam int MAX_NODES = 256;
	localparam int COORD_W   = 32;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int NODE_W    = 3 * COORD_W;
	localparam int WGT_W     = 37;
	localparam int ACC_W     = 64;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_EVAL   = 2'd1;
	localparam logic [1:0] ACT_CLOSE  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOSEG = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] node_x;
		logic signed [31:0] node_y;
		logic signed [31:0] node_z;
		logic [31:0]        curve_param;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tan_x;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_z;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} node_t;

	typedef logic signed [WGT_W-1:0] wgt_t;

	typedef struct packed {
		logic       clear;
		logic       valid;
		logic [1:0] sel;
	} mac_ctl_t;

	typedef logic signed [3:0] coef_t;

	localparam coef_t CR_B [4][4] = '{
		'{4'sd0, -4'sd1, 4'sd2, -4'sd1},
		'{4'sd2, 4'sd0, -4'sd5, 4'sd3},
		'{4'sd0, 4'sd1, 4'sd4, -4'sd3},
		'{4'sd0, 4'sd0, -4'sd1, 4'sd1}
	};

	localparam coef_t BS_B [4][4] = '{
		'{4'sd1, -4'sd3, 4'sd3, -4'sd1},
		'{4'sd4, 4'sd0, -4'sd6, 4'sd3},
		'{4'sd1, 4'sd3, 4'sd3, -4'sd3},
		'{4'sd0, 4'sd0, 4'sd0, 4'sd1}
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_CLOSE,
		ST_EVAL_W,
		ST_EVAL_RD,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		WS_IDLE,
		WS_CUBE,
		WS_NUM,
		WS_LOAD,
		WS_M1,
		WS_M2,
		WS_M3,
		WS_FIX,
		WS_DONE
	} wgt_stage_t;

endpackage

[design/cubic_spline_point_evaluator.sv]
// cubic_spline_point_evaluator: top level, control sequencer, node memory and output register
// depends on csp_pkg, csp_ram, csp_weights, csp_modk, csp_mac
//
// Usage: items enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. Every item gives exactly one result. basis_select is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, and nothing in the block enforces this. One item is taken at a
// time. Evaluate waits on the weight unit (u powers, weight numerators,
// rounding, and a shift-and-add multiply by one third for B-spline rounding;
// the segment modulo runs in parallel), then makes the four reads of the
// single read port node memory, which feed the multiply-accumulate pipeline
// behind it, and last loads the output register and returns to idle.
// Reset clears node count and basis selection; the node memory is not
// cleared, every entry is written before it can be read.
// The result sits in an output register; a new item is taken while it waits,
// but the next result is held back until the receiver takes the previous one.
module cubic_spline_point_evaluator import csp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	state_t            state_q, state_d;
	in_item_t          item_q;
	logic [CNT_W-1:0]  nc_q;
	logic              basis_q;
	logic [1:0]        status_q;
	logic              eval_ok_q;
	logic [2:0]        cnt_q;
	logic              rd_pend_q;
	logic [1:0]        rd_sel_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept;
	logic              eval_start;
	logic              close_ok;
	logic              load_out;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;
	logic              wgt_done, mod_done;
	logic [CNT_W-1:0]  k;
	logic [CNT_W:0]    idx;
	logic [CNT_W-1:0]  cl_addr;
	logic [CNT_W:0]    room;
	wgt_t [3:0]        wp, wt;
	mac_ctl_t          mac_ctl;
	logic [5:0][COORD_W-1:0] res;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign room      = {1'b0, nc_q} + (CNT_W+1)'(3);
	assign close_ok  = (nc_q >= CNT_W'(3)) && (room <= (CNT_W+1)'(MAX_NODES));
	assign idx       = {1'b0, k} + (CNT_W+1)'(cnt_q);
	assign cl_addr   = nc_q + CNT_W'(cnt_q) - CNT_W'(1);

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		eval_start = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_data.action)
						ACT_APPEND: state_d = (nc_q < CNT_W'(MAX_NODES)) ? ST_APPEND : ST_DONE;
						ACT_EVAL: begin
							if (nc_q >= CNT_W'(3)) begin
								state_d    = ST_EVAL_W;
								eval_start = 1'b1;
							end else begin
								state_d = ST_DONE;
							end
						end
						ACT_CLOSE: state_d = close_ok ? ST_CLOSE : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_APPEND: begin
				ram_we    = 1'b1;
				ram_waddr = nc_q[ADDR_W-1:0];
				ram_wdata = {item_q.node_x, item_q.node_y, item_q.node_z};
				state_d   = ST_DONE;
			end
			ST_CLOSE: begin
				ram_re    = (cnt_q < 3'd3);
				ram_raddr = ADDR_W'(cnt_q);
				ram_we    = (cnt_q != 3'd0);
				ram_waddr = cl_addr[ADDR_W-1:0];
				if (cnt_q == 3'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_EVAL_W: begin
				if (wgt_done && mod_done) begin
					state_d = ST_EVAL_RD;
				end
			end
			ST_EVAL_RD: begin
				ram_re = (cnt_q < 3'd4);
				if (idx >= {1'b0, nc_q}) begin
					ram_raddr = ADDR_W'(nc_q - CNT_W'(1));
				end else begin
					ram_raddr = idx[ADDR_W-1:0];
				end
				if (cnt_q == 3'd5) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nc_q        <= '0;
			basis_q     <= 1'b0;
			cnt_q       <= 3'd0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= (state_q == ST_EVAL_RD) && (cnt_q < 3'd4);
			if (cfg_wr_en) begin
				basis_q <= cfg_wr_data;
			end
			if (accept) begin
				cnt_q <= 3'd0;
			end else if (state_q == ST_CLOSE || state_q == ST_EVAL_RD) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (state_q == ST_APPEND) begin
				nc_q <= nc_q + CNT_W'(1);
			end else if (state_q == ST_CLOSE && cnt_q == 3'd3) begin
				nc_q <= nc_q + CNT_W'(3);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_q <= cnt_q[1:0];
		if (accept) begin
			item_q    <= in_data;
			eval_ok_q <= (in_data.action == ACT_EVAL) && (nc_q >= CNT_W'(3));
			priority if (in_data.action == ACT_APPEND && nc_q >= CNT_W'(MAX_NODES)) begin
				status_q <= STAT_FULL;
			end else if (in_data.action == ACT_EVAL && nc_q < CNT_W'(3)) begin
				status_q <= STAT_NOSEG;
			end else if (in_data.action == ACT_CLOSE && nc_q >= CNT_W'(3) && !close_ok) begin
				status_q <= STAT_FULL;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if (load_out) begin
			out_q.status <= status_q;
			out_q.pos_x  <= eval_ok_q ? res[0] : '0;
			out_q.pos_y  <= eval_ok_q ? res[1] : '0;
			out_q.pos_z  <= eval_ok_q ? res[2] : '0;
			out_q.tan_x  <= eval_ok_q ? res[3] : '0;
			out_q.tan_y  <= eval_ok_q ? res[4] : '0;
			out_q.tan_z  <= eval_ok_q ? res[5] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign mac_ctl.clear = eval_start;
	assign mac_ctl.valid = rd_pend_q;
	assign mac_ctl.sel   = rd_sel_q;

	csp_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	csp_weights u_weights (
		.clk   (clk),
		.arst_n(arst_n),
		.start (eval_start),
		.basis (basis_q),
		.u     (in_data.curve_param[15:0]),
		.wp    (wp),
		.wt    (wt),
		.done  (wgt_done)
	);

	csp_modk u_modk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eval_start),
		.dividend(in_data.curve_param[31:16]),
		.divisor (nc_q - CNT_W'(2)),
		.rem     (k),
		.done    (mod_done)
	);

	csp_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.node  (node_t'(ram_rdata)),
		.wp    (wp),
		.wt    (wt),
		.res   (res)
	);

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("node memory read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nc_q <= CNT_W'(MAX_NODES))
		else $error("node count past store size");

	a_weights_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL_RD |-> wgt_done && mod_done)
		else $error("node reads started before weights and segment index");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL_RD && ram_re |-> CNT_W'(ram_raddr) < nc_q)
		else $error("evaluate read beyond stored nodes");
`endif

endmodule

[design/csp_ram.sv]
// csp_ram: generic single write port, single read port ram with registered read
// no dependencies
module csp_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/csp_weights.sv]
// csp_weights: basis weight unit, u powers, weight numerators and multiply by one third
// depends on csp_pkg
module csp_weights import csp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             basis,
	input  logic [15:0]      u,
	output wgt_t [3:0]       wp,
	output wgt_t [3:0]       wt,
	output logic             done
);

	localparam int NUM_W = 56;
	localparam int DIV_W = 40;
	localparam logic [DIV_W-1:0] DIV_BIAS = 40'h60_0000_0000;

	wgt_stage_t  stg_q, stg_d;
	logic [15:0] u_q;
	logic [31:0] u2_q;
	logic [47:0] u3_q;

	logic signed [NUM_W-1:0] num_q [8];
	logic signed [NUM_W-1:0] num_d [8];
	wgt_t                    m_q   [8];
	wgt_t                    m_d   [8];
	logic [DIV_W-1:0]        n_q   [8];
	logic [46:0]             a55_q [8];
	logic [54:0]             a5555_q [8];
	logic [DIV_W-1:0]        q_q   [8];

	logic [42:0]             a5_d    [8];
	logic [46:0]             a55_d   [8];
	logic [54:0]             a5555_d [8];
	logic [79:0]             prod_d  [8];
	logic [2:0]              r3_d    [8];

	logic signed [NUM_W-1:0] tone, tu, tu2, tu3, half;
	logic signed [NUM_W-1:0] rsum [8];
	coef_t                   c [4][4];

	always_comb begin
		tone = {7'b0, 1'b1, 48'b0};
		tu   = {8'b0, u_q, 32'b0};
		tu2  = {8'b0, u2_q, 16'b0};
		tu3  = {8'b0, u3_q};
		half = basis ? 56'sd786432 : 56'sd262144;
		for (int j = 0; j < 4; j++) begin
			for (int k = 0; k < 4; k++) begin
				c[j][k] = basis ? BS_B[j][k] : CR_B[j][k];
			end
			num_d[j]     = c[j][0] * tone + c[j][1] * tu + c[j][2] * tu2 + c[j][3] * tu3;
			num_d[j + 4] = c[j][1] * tone + c[j][2] * (tu <<< 1)
				+ c[j][3] * (tu2 + (tu2 <<< 1));
		end
		for (int j = 0; j < 8; j++) begin
			rsum[j] = num_q[j] + half;
			m_d[j]  = rsum[j][NUM_W-1:19];
		end
	end

	// n * 0x5555555555 by shift and add, then the low bits of n - 3q fix the estimate
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			a5_d[j]    = {3'b0, n_q[j]} + {1'b0, n_q[j], 2'b0};
			a55_d[j]   = {4'b0, a5_d[j]} + {a5_d[j], 4'b0};
			a5555_d[j] = {8'b0, a55_q[j]} + {a55_q[j], 8'b0};
			prod_d[j]  = {25'b0, a5555_q[j]} + {9'b0, a5555_q[j], 16'b0}
				+ {1'b0, a55_q[j], 32'b0};
			r3_d[j]    = n_q[j][2:0] - q_q[j][2:0] - {q_q[j][1:0], 1'b0};
		end
	end

	always_comb begin
		stg_d = stg_q;
		if (start) begin
			stg_d = WS_CUBE;
		end else begin
			unique case (stg_q)
				WS_CUBE: stg_d = WS_NUM;
				WS_NUM:  stg_d = WS_LOAD;
				WS_LOAD: stg_d = WS_M1;
				WS_M1:   stg_d = WS_M2;
				WS_M2:   stg_d = WS_M3;
				WS_M3:   stg_d = WS_FIX;
				WS_FIX:  stg_d = WS_DONE;
				default: stg_d = stg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= WS_IDLE;
		end else begin
			stg_q <= stg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q  <= u;
			u2_q <= u * u;
		end
		if (stg_q == WS_CUBE) begin
			u3_q <= u2_q * u_q;
		end
		for (int j = 0; j < 8; j++) begin
			if (stg_q == WS_NUM) begin
				num_q[j] <= num_d[j];
			end
			if (stg_q == WS_LOAD) begin
				m_q[j] <= m_d[j];
				n_q[j] <= {{(DIV_W-WGT_W){m_d[j][WGT_W-1]}}, m_d[j]} + DIV_BIAS;
			end
			if (stg_q == WS_M1) begin
				a55_q[j] <= a55_d[j];
			end
			if (stg_q == WS_M2) begin
				a5555_q[j] <= a5555_d[j];
			end
			if (stg_q == WS_M3) begin
				q_q[j] <= prod_d[j][79:40];
			end else if (stg_q == WS_FIX && r3_d[j] >= 3'd3) begin
				q_q[j] <= q_q[j] + 40'd1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			wp[j] = basis ? q_q[j][WGT_W-1:0] : m_q[j];
			wt[j] = basis ? q_q[j + 4][WGT_W-1:0] : m_q[j + 4];
		end
	end

	assign done = (stg_q == WS_DONE);

endmodule

[design/csp_modk.sv]
// csp_modk: segment index reduction modulo the segment count, four bits a cycle
// depends on csp_pkg
module csp_modk import csp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [15:0]      dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [CNT_W-1:0] rem,
	output logic             done
);

	logic [15:0]      dvd_q;
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] r_d;
	logic [1:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   t;

	always_comb begin
		r_d = r_q;
		t   = '0;
		for (int b = 15; b >= 12; b--) begin
			t = {r_d, dvd_q[b]};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
			end
			r_d = t[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 4;
			r_q   <= r_d;
		end
	end

	assign rem  = r_q;
	assign done = done_q;

endmodule

[design/csp_mac.sv]
// csp_mac: split multiply and 64-bit accumulate of node coordinates by basis weights
// depends on csp_pkg
module csp_mac import csp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mac_ctl_t                  ctl,
	input  node_t                     node,
	input  wgt_t [3:0]                wp,
	input  wgt_t [3:0]                wt,
	output logic [5:0][COORD_W-1:0]   res
);

	logic signed [COORD_W-1:0] v [3];
	wgt_t                      w [6];
	logic signed [51:0]        pl_s1 [6];
	logic signed [49:0]        ph_s1 [6];
	logic                      valid_s1;
	logic [ACC_W-1:0]          acc_q [6];
	logic [ACC_W-1:0]          rnd   [6];
	logic [33:0]               sh    [6];

	always_comb begin
		v[0] = node.x;
		v[1] = node.y;
		v[2] = node.z;
		for (int c = 0; c < 3; c++) begin
			w[c]     = $signed(wp[ctl.sel]);
			w[c + 3] = $signed(wt[ctl.sel]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			if (ctl.valid) begin
				pl_s1[k] <= v[k % 3] * $signed({1'b0, w[k][18:0]});
				ph_s1[k] <= v[k % 3] * $signed(w[k][WGT_W-1:19]);
			end
			if (ctl.clear) begin
				acc_q[k] <= '0;
			end else if (valid_s1) begin
				acc_q[k] <= acc_q[k] + ({{(ACC_W-50){ph_s1[k][49]}}, ph_s1[k]} << 19)
					+ {{(ACC_W-52){pl_s1[k][51]}}, pl_s1[k]};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			rnd[k] = acc_q[k] + 64'd536870912;
			sh[k]  = rnd[k][ACC_W-1:30];
			if (sh[k][33:31] == 3'b000 || sh[k][33:31] == 3'b111) begin
				res[k] = sh[k][31:0];
			end else if (sh[k][33]) begin
				res[k] = 32'h8000_0000;
			end else begin
				res[k] = 32'h7FFF_FFFF;
			end
		end
	end

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for cubic_spline_point_evaluator
// depends on csp_pkg and the design top; a directed table runs first, then random
// traffic under three idling profiles and both basis settings, checked against a predictor
`timescale 1ns / 100ps

module tb_top;
	import csp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RAND_PER_PHASE = 215;

	localparam longint CR_COEF [4][4] = '{
		'{0, -1, 2, -1}, '{2, 0, -5, 3}, '{0, 1, 4, -3}, '{0, 0, -1, 1}
	};
	localparam longint BS_COEF [4][4] = '{
		'{1, -3, 3, -1}, '{4, 0, -6, 3}, '{1, 3, 3, -3}, '{0, 0, 0, 1}
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_wr_en;
	logic      cfg_wr_data;

	cubic_spline_point_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// predictor state
	longint    ctl_pts [MAX_NODES][3];
	int        pt_count;
	int        seg_count;
	bit        basis_sel;

	out_item_t pending_results [$];
	int        mismatches;
	int        items_sent;
	int        results_seen;
	int        evals_ok;
	int        idle_cycles;
	int        send_idle_pct;
	int        recv_stall_pct;

	typedef struct {
		in_item_t  item;
		bit        typed;
		logic [1:0] status;
	} dir_row_t;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic out_item_t eval_curve(logic [31:0] param);
		out_item_t r;
		longint    bm [4][4];
		longint    dv, u, u2, u3, p, t, v, ap, at;
		longint    wp [4];
		longint    wt [4];
		int        k, idx;
		r = '0;
		if (basis_sel)
			bm = BS_COEF;
		else
			bm = CR_COEF;
		dv = (basis_sel ? 64'sd6 : 64'sd2) * (64'sd1 <<< 18);
		u = longint'(param[15:0]);
		u2 = u * u;
		u3 = u2 * u;
		k = int'(param[31:16]) % seg_count;
		for (int i = 0; i < 4; i++) begin
			p = bm[i][0] * (64'sd1 <<< 48) + bm[i][1] * u * (64'sd1 <<< 32)
				+ bm[i][2] * u2 * (64'sd1 <<< 16) + bm[i][3] * u3;
			t = bm[i][1] * (64'sd1 <<< 48) + 2 * bm[i][2] * u * (64'sd1 <<< 32)
				+ 3 * bm[i][3] * u2 * (64'sd1 <<< 16);
			wp[i] = floor_div(p + dv / 2, dv);
			wt[i] = floor_div(t + dv / 2, dv);
		end
		for (int c = 0; c < 3; c++) begin
			ap = 0;
			at = 0;
			for (int i = 0; i < 4; i++) begin
				idx = k + i;
				if (idx >= pt_count)
					idx = pt_count - 1;
				if (idx >= MAX_NODES)
					idx = MAX_NODES - 1;
				v = ctl_pts[idx][c];
				ap = ap + v * wp[i];
				at = at + v * wt[i];
			end
			ap = floor_div(ap + (64'sd1 <<< 29), 64'sd1 <<< 30);
			at = floor_div(at + (64'sd1 <<< 29), 64'sd1 <<< 30);
			case (c)
				0: begin r.pos_x = sat32(ap); r.tan_x = sat32(at); end
				1: begin r.pos_y = sat32(ap); r.tan_y = sat32(at); end
				default: begin r.pos_z = sat32(ap); r.tan_z = sat32(at); end
			endcase
		end
		return r;
	endfunction

	function automatic out_item_t spline_predict(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.action)
			ACT_APPEND: begin
				if (pt_count >= MAX_NODES) begin
					r.status = STAT_FULL;
				end else begin
					ctl_pts[pt_count][0] = longint'(it.node_x);
					ctl_pts[pt_count][1] = longint'(it.node_y);
					ctl_pts[pt_count][2] = longint'(it.node_z);
					pt_count++;
					if (pt_count >= 3)
						seg_count++;
				end
			end
			ACT_EVAL: begin
				if (seg_count == 0 || pt_count == 0)
					r.status = STAT_NOSEG;
				else
					r = eval_curve(it.curve_param);
			end
			ACT_CLOSE: begin
				if (pt_count >= 3) begin
					if (pt_count + 3 > MAX_NODES) begin
						r.status = STAT_FULL;
					end else begin
						for (int j = 0; j < 3; j++)
							for (int c = 0; c < 3; c++)
								ctl_pts[pt_count + j][c] = ctl_pts[j][c];
						pt_count += 3;
						seg_count += 3;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic in_item_t mk(logic [1:0] act, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] prm);
		in_item_t it;
		it.action = act;
		it.node_x = x;
		it.node_y = y;
		it.node_z = z;
		it.curve_param = prm;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h7fffffff) & 32'h001fffff ^ ($urandom_range(1) ? 32'hfff00000 : 32'h0);
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $urandom_range(32'h0003ffff) - 32'h00020000;
		endcase
	endfunction

	function automatic logic [31:0] rand_param();
		logic [15:0] seg;
		logic [15:0] frac;
		seg = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(12));
		case ($urandom_range(5))
			0: frac = 16'h0000;
			1: frac = 16'hffff;
			default: frac = 16'($urandom);
		endcase
		return {seg, frac};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("result %0d: %s got %h want %h", results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic send_item(in_item_t it, bit typed, logic [1:0] typed_status);
		out_item_t exp_res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		exp_res = spline_predict(it);
		if (typed) begin
			exp_res = '0;
			exp_res.status = typed_status;
		end
		pending_results.insert(pending_results.size(), exp_res);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic set_basis(bit b);
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = b;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		basis_sel = b;
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			send_item(mk(ACT_APPEND, rand_coord(), rand_coord(), rand_coord(), $urandom), 0, STAT_OK);
		else if (r < 88)
			send_item(mk(ACT_EVAL, $urandom, $urandom, $urandom, rand_param()), 0, STAT_OK);
		else if (r < 95)
			send_item(mk(ACT_CLOSE, $urandom, $urandom, $urandom, $urandom), 0, STAT_OK);
		else
			send_item(mk(2'd3, $urandom, $urandom, $urandom, $urandom), 0, STAT_OK);
	endtask

	// receiver stall
	always @(negedge clk)
		out_stall = ($urandom_range(99) < recv_stall_pct);

	// result check and watchdog
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("result %0d: transfer with nothing expected", results_seen);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.pos_x != want.pos_x) report_mismatch("pos_x", out_data.pos_x, want.pos_x);
				if (out_data.pos_y != want.pos_y) report_mismatch("pos_y", out_data.pos_y, want.pos_y);
				if (out_data.pos_z != want.pos_z) report_mismatch("pos_z", out_data.pos_z, want.pos_z);
				if (out_data.tan_x != want.tan_x) report_mismatch("tan_x", out_data.tan_x, want.tan_x);
				if (out_data.tan_y != want.tan_y) report_mismatch("tan_y", out_data.tan_y, want.tan_y);
				if (out_data.tan_z != want.tan_z) report_mismatch("tan_z", out_data.tan_z, want.tan_z);
				if (want.status == STAT_OK && (want.pos_x | want.tan_x | want.pos_y) != 0)
					evals_ok++;
			end
			results_seen++;
		end
		if ((arst_n && out_valid && !out_stall) || (in_valid && !in_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d results", results_seen);
			$display("cubic_spline_point_evaluator: mismatch");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		evals_ok = 0;
		idle_cycles = 0;
		pt_count = 0;
		seg_count = 0;
		basis_sel = 1'b0;
		for (int i = 0; i < MAX_NODES; i++)
			for (int c = 0; c < 3; c++)
				ctl_pts[i][c] = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// evaluate before any segment, close with too few nodes, unused code
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h0), 1, STAT_NOSEG});
		rows.insert(rows.size(), '{mk(ACT_CLOSE, 0, 0, 0, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_APPEND, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_APPEND, 32'h80000000, 32'h80000000, 32'h80000000, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h00010000), 1, STAT_NOSEG});
		rows.insert(rows.size(), '{mk(ACT_CLOSE, 0, 0, 0, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_APPEND, 0, 0, 0, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h00000000), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'hffffffff), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_APPEND, 32'h00010000, 32'h00020000, 32'hfffd0000, 0), 1, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h00008000), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h00014000), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_CLOSE, 0, 0, 0, 0), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h0004ffff), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'h00060000), 0, STAT_OK});
		rows.insert(rows.size(), '{mk(ACT_EVAL, 0, 0, 0, 32'hffff0001), 0, STAT_OK});

		set_basis(1'b0);
		send_idle_pct = 20;
		recv_stall_pct = 81;
		foreach (rows[i])
			send_item(rows[i].item, rows[i].typed, rows[i].status);
		set_basis(1'b1);
		for (int i = 0; i < 4; i++)
			send_item(mk(ACT_EVAL, 0, 0, 0, rand_param()), 0, STAT_OK);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 81 : 0;
			recv_stall_pct = (ph == 0) ? 81 : (ph == 1) ? 20 : 0;
			set_basis(ph != 1);
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				if (i == RAND_PER_PHASE / 2)
					set_basis(ph == 1);
				send_random();
			end
		end

		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d items, checked %0d results, %0d nonzero evaluations",
			items_sent, results_seen, evals_ok);
		$display("node store ended with %0d nodes and %0d segments", pt_count, seg_count);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("cubic_spline_point_evaluator: match");
		else
			$display("cubic_spline_point_evaluator: mismatch");
		$finish;
	end

endmodule
